### design/delta_list_timer_queue_macros.svh
// Assertion macros for the delta-list timer queue.
// Used by the top level; expects aclk and aresetn in the enclosing scope.
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DLTQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dltq assertion failed");
`define DLTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dltq assertion failed");
`else
`define DLTQ_ASSERT_IMP(lbl, ante, cons)
`define DLTQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
// No dependencies; used by dltq_alu, delta_list_timer_queue and the testbench.
`default_nettype none
package dltq_pkg;
    localparam int NUM_TIMERS_DEF  = 16;
    localparam int DELAY_WIDTH_DEF = 32;
    localparam int TID_W           = 4;
    localparam int PERIOD_W        = 32;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_STOP   = 2'd1,
        EV_EXPIRE = 2'd2
    } ev_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;
endpackage
`default_nettype wire

### design/dltq_alu.sv
// Shared add/subtract unit with unsigned compare for the timer queue sequencer.
// Depends on dltq_pkg (alu_op_t).
`default_nettype none
module dltq_alu #(
    parameter int W = dltq_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic [W-1:0]      a,
    input  wire logic [W-1:0]      b,
    input  wire dltq_pkg::alu_op_t op,
    output logic      [W-1:0]      y,
    output logic                   ge
);
    logic [W:0] sum;

    // Subtract as a plus inverted b plus one; carry out means a >= b
    always_comb begin
        if (op == dltq_pkg::ALU_SUB) begin
            sum = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
        end else begin
            sum = {1'b0, a} + {1'b0, b};
        end
        y  = sum[W-1:0];
        ge = sum[W];
    end
endmodule
`default_nettype wire

### design/delta_list_timer_queue.sv
// Delta-list timer queue: top level with the list sequencer and slot memories.
// Depends on dltq_pkg, dltq_alu and delta_list_timer_queue_macros.svh.
//
//   channel  | dir | tdata (low bit up)                       | tuser     | tlast
//   s_       | in  | timer_id[3:0] period[35:4] reload[36]    | operation | -
//   m_       | out | timer_id_res[3:0] ok[4]                  | event_kind| last
//
// A rejected or already linked start goes straight to its result; an insert walks
// the list slot by slot, paced by the single read port of the node memory and the
// shared add/subtract unit. Stop walks to the predecessor of its slot unless it is
// the head; a tick decrements the head and expires each slot that reaches zero,
// running the insert walk again for each reloading slot.
// Reset clears the list head and the linked bits and sets the empty flag at once.
// A result waits in the output register; the sequencer holds while it is full.
`default_nettype none
`include "delta_list_timer_queue_macros.svh"
module delta_list_timer_queue #(
    parameter int NUM_TIMERS  = dltq_pkg::NUM_TIMERS_DEF,
    parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // timer_id[3:0], period[35:4], reload[36], zeros
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // timer_id_res[3:0], ok[4], zeros
    output logic [1:0]       m_tuser,   // event_kind[1:0]
    output logic             m_tlast
);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int DW = DELAY_WIDTH;

    typedef struct packed {
        logic          nv;
        logic [IW-1:0] ns;
        logic [DW-1:0] dl;
    } node_t;

    typedef struct packed {
        logic          rl;
        logic [DW-1:0] dl;
    } prd_t;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_EMIT     = 17'h00002,
        ST_LK_START = 17'h00004,
        ST_LK_HEAD  = 17'h00008,
        ST_LK_HSUB  = 17'h00010,
        ST_LK_STEP  = 17'h00020,
        ST_LK_CMP   = 17'h00040,
        ST_LK_NSUB  = 17'h00080,
        ST_LK_WCUR  = 17'h00100,
        ST_LK_WID   = 17'h00200,
        ST_SP_HEAD  = 17'h00400,
        ST_SP_WALK  = 17'h00800,
        ST_SP_UNL   = 17'h01000,
        ST_SP_ADD   = 17'h02000,
        ST_TK_DEC   = 17'h04000,
        ST_TK_MORE  = 17'h08000,
        ST_TK_RL    = 17'h10000
    } state_t;

    // Slot memories
    node_t node_mem [NUM_TIMERS];
    prd_t  prd_mem  [NUM_TIMERS];

    state_t              state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next;
    logic                empty_reg, empty_next;
    logic [NUM_TIMERS-1:0] linked_reg, linked_next;
    logic [IW-1:0]       lid_reg, lid_next;
    logic [3:0]          id4_reg, id4_next;
    logic [DW-1:0]       d_reg, d_next;
    logic                rl_reg, rl_next;
    logic [IW-1:0]       cur_reg, cur_next;
    node_t               cur_node_reg, cur_node_next;
    node_t               nxt_node_reg, nxt_node_next;
    node_t               wnode_reg, wnode_next;
    logic                more_reg, more_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    dltq_pkg::ev_t       res_kind_reg, res_kind_next;
    logic                res_ok_reg, res_ok_next;
    logic                res_last_reg, res_last_next;

    node_t               node_rd_reg;
    prd_t                prd_rd_reg;

    logic                m_tvalid_reg;
    logic [1:0]          m_kind_reg;
    logic [3:0]          m_id_reg;
    logic                m_ok_reg;
    logic                m_last_reg;

    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    node_t               wr_data;
    logic                prd_wr_en;
    logic                load_out;
    logic                out_free;

    logic [DW-1:0]       alu_a, alu_b, alu_y;
    dltq_pkg::alu_op_t   alu_op;
    logic                alu_ge;

    logic [IW-1:0]       in_idx;
    logic [DW-1:0]       in_d;
    logic                in_id_ok;

    dltq_alu #(.W(DW)) u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y),
        .ge (alu_ge)
    );

    // Unpack the input transfer
    assign in_idx   = IW'(s_tdata[3:0]);
    assign in_d     = DW'(s_tdata[35:4]);
    assign in_id_ok = ({3'b000, s_tdata[3:0]} < 7'(NUM_TIMERS));
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        empty_next     = empty_reg;
        linked_next    = linked_reg;
        lid_next       = lid_reg;
        id4_next       = id4_reg;
        d_next         = d_reg;
        rl_next        = rl_reg;
        cur_next       = cur_reg;
        cur_node_next  = cur_node_reg;
        nxt_node_next  = nxt_node_reg;
        wnode_next     = wnode_reg;
        more_next      = more_reg;
        cnt_next       = cnt_reg;
        res_kind_next  = res_kind_reg;
        res_ok_next    = res_ok_reg;
        res_last_next  = res_last_reg;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = node_rd_reg;
        prd_wr_en      = 1'b0;
        load_out       = 1'b0;
        alu_a          = '0;
        alu_b          = '0;
        alu_op         = dltq_pkg::ALU_SUB;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    lid_next       = in_idx;
                    id4_next       = s_tdata[3:0];
                    d_next         = in_d;
                    cnt_next       = '0;
                    res_last_next  = 1'b1;
                    unique case (dltq_pkg::op_t'(s_tuser))
                        dltq_pkg::OP_START: begin
                            res_kind_next = dltq_pkg::EV_START;
                            res_ok_next   = 1'b1;
                            if (!in_id_ok || in_d == '0) begin
                                res_ok_next = 1'b0;
                                state_next  = ST_EMIT;
                            end else if (linked_reg[in_idx]) begin
                                state_next = ST_EMIT;
                            end else begin
                                prd_wr_en  = 1'b1;
                                state_next = ST_LK_START;
                            end
                        end
                        dltq_pkg::OP_STOP: begin
                            res_kind_next = dltq_pkg::EV_STOP;
                            res_ok_next   = 1'b0;
                            if (!in_id_ok || empty_reg || !linked_reg[in_idx]) begin
                                state_next = ST_EMIT;
                            end else if (head_reg == in_idx) begin
                                state_next = ST_SP_HEAD;
                            end else begin
                                cur_next   = head_reg;
                                state_next = ST_SP_WALK;
                            end
                        end
                        dltq_pkg::OP_TICK: begin
                            if (!empty_reg) begin
                                state_next = ST_TK_DEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Hand the pending result to the output register
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_TK_DEC;
                    end
                end
            end

            // Insert slot lid with delay d; head node is being read
            ST_LK_START: begin
                if (empty_reg) begin
                    head_next  = lid_reg;
                    empty_next = 1'b0;
                    wnode_next = '{nv: 1'b0, ns: '0, dl: d_reg};
                    state_next = ST_LK_WID;
                end else begin
                    state_next = ST_LK_HEAD;
                end
            end
            ST_LK_HEAD: begin
                alu_a = node_rd_reg.dl;
                alu_b = d_reg;
                if (alu_ge) begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = '{nv: node_rd_reg.nv, ns: node_rd_reg.ns, dl: alu_y};
                    wnode_next = '{nv: 1'b1, ns: head_reg, dl: d_reg};
                    head_next  = lid_reg;
                    state_next = ST_LK_WID;
                end else begin
                    cur_next      = head_reg;
                    cur_node_next = node_rd_reg;
                    state_next    = ST_LK_HSUB;
                end
            end
            ST_LK_HSUB: begin
                alu_a      = d_reg;
                alu_b      = cur_node_reg.dl;
                d_next     = alu_y;
                state_next = ST_LK_STEP;
            end
            ST_LK_STEP: begin
                if (cur_node_reg.nv) begin
                    rd_addr    = cur_node_reg.ns;
                    state_next = ST_LK_CMP;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg;
                    wr_data    = '{nv: 1'b1, ns: lid_reg, dl: cur_node_reg.dl};
                    wnode_next = '{nv: 1'b0, ns: '0, dl: d_reg};
                    state_next = ST_LK_WID;
                end
            end
            ST_LK_CMP: begin
                alu_a = d_reg;
                alu_b = node_rd_reg.dl;
                if (alu_ge) begin
                    d_next        = alu_y;
                    cur_next      = cur_node_reg.ns;
                    cur_node_next = node_rd_reg;
                    state_next    = ST_LK_STEP;
                end else begin
                    nxt_node_next = node_rd_reg;
                    state_next    = ST_LK_NSUB;
                end
            end
            ST_LK_NSUB: begin
                alu_a      = nxt_node_reg.dl;
                alu_b      = d_reg;
                wr_en      = 1'b1;
                wr_addr    = cur_node_reg.ns;
                wr_data    = '{nv: nxt_node_reg.nv, ns: nxt_node_reg.ns, dl: alu_y};
                wnode_next = '{nv: 1'b1, ns: cur_node_reg.ns, dl: d_reg};
                state_next = ST_LK_WCUR;
            end
            ST_LK_WCUR: begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_data    = '{nv: 1'b1, ns: lid_reg, dl: cur_node_reg.dl};
                state_next = ST_LK_WID;
            end
            ST_LK_WID: begin
                wr_en               = 1'b1;
                wr_addr             = lid_reg;
                wr_data             = wnode_reg;
                linked_next[lid_reg] = 1'b1;
                state_next          = ST_EMIT;
            end

            // Stop of the head slot; node of lid is being read
            ST_SP_HEAD: begin
                linked_next[lid_reg] = 1'b0;
                res_ok_next          = 1'b1;
                if (node_rd_reg.nv) begin
                    head_next     = node_rd_reg.ns;
                    cur_node_next = node_rd_reg;
                    rd_addr       = node_rd_reg.ns;
                    state_next    = ST_SP_ADD;
                end else begin
                    empty_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            // Walk to the predecessor of lid
            ST_SP_WALK: begin
                if (node_rd_reg.nv && node_rd_reg.ns == lid_reg) begin
                    cur_node_next = node_rd_reg;
                    rd_addr       = lid_reg;
                    state_next    = ST_SP_UNL;
                end else if (node_rd_reg.nv) begin
                    cur_next = node_rd_reg.ns;
                    rd_addr  = node_rd_reg.ns;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SP_UNL: begin
                wr_en                = 1'b1;
                wr_addr              = cur_reg;
                wr_data              = '{nv: node_rd_reg.nv, ns: node_rd_reg.ns,
                                         dl: cur_node_reg.dl};
                linked_next[lid_reg] = 1'b0;
                res_ok_next          = 1'b1;
                if (node_rd_reg.nv) begin
                    cur_node_next = node_rd_reg;
                    rd_addr       = node_rd_reg.ns;
                    state_next    = ST_SP_ADD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            // Fold the removed delta into the successor
            ST_SP_ADD: begin
                alu_a      = node_rd_reg.dl;
                alu_b      = cur_node_reg.dl;
                alu_op     = dltq_pkg::ALU_ADD;
                wr_en      = 1'b1;
                wr_addr    = cur_node_reg.ns;
                wr_data    = '{nv: node_rd_reg.nv, ns: node_rd_reg.ns, dl: alu_y};
                state_next = ST_EMIT;
            end

            // Tick: decrement the head, expire it on zero
            ST_TK_DEC: begin
                alu_a    = node_rd_reg.dl;
                alu_b    = DW'(node_rd_reg.dl != '0);
                wr_en    = 1'b1;
                wr_addr  = head_reg;
                wr_data  = '{nv: node_rd_reg.nv, ns: node_rd_reg.ns, dl: alu_y};
                lid_next = head_reg;
                d_next   = prd_rd_reg.dl;
                rl_next  = prd_rd_reg.rl;
                if (alu_y != '0) begin
                    state_next = ST_IDLE;
                end else begin
                    linked_next[head_reg] = 1'b0;
                    res_kind_next         = dltq_pkg::EV_EXPIRE;
                    res_ok_next           = 1'b1;
                    id4_next              = 4'(head_reg);
                    if (node_rd_reg.nv) begin
                        head_next  = node_rd_reg.ns;
                        rd_addr    = node_rd_reg.ns;
                        state_next = ST_TK_MORE;
                    end else begin
                        empty_next = 1'b1;
                        more_next  = 1'b0;
                        state_next = ST_TK_RL;
                    end
                end
            end
            ST_TK_MORE: begin
                more_next  = (node_rd_reg.dl == '0);
                state_next = ST_TK_RL;
            end
            ST_TK_RL: begin
                res_last_next = !(more_reg && cnt_reg != IW'(NUM_TIMERS - 1));
                if (rl_reg) begin
                    state_next = ST_LK_START;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            empty_reg  <= 1'b1;
            linked_reg <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            empty_reg  <= empty_next;
            linked_reg <= linked_next;
        end
        lid_reg       <= lid_next;
        id4_reg       <= id4_next;
        d_reg         <= d_next;
        rl_reg        <= rl_next;
        cur_reg       <= cur_next;
        cur_node_reg  <= cur_node_next;
        nxt_node_reg  <= nxt_node_next;
        wnode_reg     <= wnode_next;
        more_reg      <= more_next;
        cnt_reg       <= cnt_next;
        res_kind_reg  <= res_kind_next;
        res_ok_reg    <= res_ok_next;
        res_last_reg  <= res_last_next;
    end

    // Node memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        node_rd_reg <= node_mem[rd_addr];
    end

    // Period and reload memory, read at the head
    always_ff @(posedge aclk) begin
        if (prd_wr_en) begin
            prd_mem[in_idx] <= '{rl: s_tdata[36], dl: in_d};
        end
        prd_rd_reg <= prd_mem[head_reg];
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (load_out) begin
            m_kind_reg <= res_kind_reg;
            m_id_reg   <= id4_reg;
            m_ok_reg   <= res_ok_reg;
            m_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_ok_reg, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `DLTQ_ASSERT_IMP(a_empty_none_linked, empty_reg, linked_reg == '0)
    `DLTQ_ASSERT_NEXT(a_emit_holds, state_reg == ST_EMIT && m_tvalid && !m_tready, state_reg == ST_EMIT)
    `DLTQ_ASSERT_NEXT(a_zero_period_reject, s_tvalid && s_tready && s_tuser == dltq_pkg::OP_START && in_d == '0, state_reg == ST_EMIT && !res_ok_reg)
    `DLTQ_ASSERT_NEXT(a_idle_links_stable, state_reg == ST_IDLE && !s_tvalid, $stable(linked_reg) && $stable(head_reg))
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the delta-list timer queue: drives start, stop
// and tick operations and checks each result against an in-bench list model.
// Depends on dltq_pkg and the delta_list_timer_queue top level.
`default_nettype none
module testbench;
    localparam int NT = 16;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] id;
        logic       ok;
        logic       last;
    } timer_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;

    delta_list_timer_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Shadow timer list
    logic [3:0]  q_head;
    logic        q_empty;
    logic [3:0]  q_next [NT];
    logic        q_nvalid [NT];
    logic [31:0] q_delta [NT];
    logic [31:0] q_period [NT];
    logic        q_reload [NT];
    logic        q_linked [NT];

    timer_event_t pending_events[$];
    int     error_count = 0;
    longint cycle_count = 0;
    int     rx_hold = 0;
    int     rx_wait = 0;

    function automatic void list_clear();
        q_head = '0;
        q_empty = 1'b1;
        for (int i = 0; i < NT; i++) begin
            q_next[i] = '0; q_nvalid[i] = 0; q_delta[i] = '0;
            q_period[i] = '0; q_reload[i] = 0; q_linked[i] = 0;
        end
    endfunction

    function automatic void list_insert(logic [3:0] id, logic [31:0] p);
        logic [31:0] d;
        logic [3:0]  cur, n;
        logic        placed;
        d = p;
        placed = 0;
        q_nvalid[id] = 0;
        q_linked[id] = 1;
        if (q_empty) begin
            q_head = id;
            q_empty = 0;
        end else if (q_delta[q_head] >= d) begin
            q_delta[q_head] = q_delta[q_head] - d;
            q_next[id] = q_head;
            q_nvalid[id] = 1;
            q_head = id;
        end else begin
            cur = q_head;
            d = d - q_delta[cur];
            for (int g = 0; g < NT && q_nvalid[cur] && !placed; g++) begin
                n = q_next[cur];
                if (d >= q_delta[n]) begin
                    d = d - q_delta[n];
                    cur = n;
                end else begin
                    q_delta[n] = q_delta[n] - d;
                    q_next[id] = n;
                    q_nvalid[id] = 1;
                    q_next[cur] = id;
                    placed = 1;
                end
            end
            if (!placed) begin
                q_next[cur] = id;
                q_nvalid[cur] = 1;
            end
        end
        q_delta[id] = d;
    endfunction

    function automatic logic list_remove(logic [3:0] id);
        logic [3:0] cur, n;
        if (q_empty || !q_linked[id]) return 0;
        if (q_head == id) begin
            if (q_nvalid[id]) begin
                q_head = q_next[id];
                q_delta[q_head] = q_delta[q_head] + q_delta[id];
            end else begin
                q_empty = 1;
            end
            q_linked[id] = 0;
            return 1;
        end
        cur = q_head;
        for (int g = 0; g < NT && q_nvalid[cur]; g++) begin
            if (q_next[cur] == id) begin
                q_nvalid[cur] = q_nvalid[id];
                q_next[cur] = q_next[id];
                if (q_nvalid[id]) begin
                    n = q_next[id];
                    q_delta[n] = q_delta[n] + q_delta[id];
                end
                q_linked[id] = 0;
                return 1;
            end
            cur = q_next[cur];
        end
        return 0;
    endfunction

    // Work out the events caused by one operation and queue them
    function automatic void predict_events(logic [1:0] op, logic [3:0] id,
                                           logic [31:0] p, logic rl);
        timer_event_t ev;
        int k;
        logic more, ok;
        logic [3:0] t;
        k = 0;
        if (op == dltq_pkg::OP_START) begin
            ok = (p != 0);
            if (ok && !q_linked[id]) begin
                q_period[id] = p;
                q_reload[id] = rl;
                list_insert(id, p);
            end
            ev = '{kind: dltq_pkg::EV_START, id: id, ok: ok, last: 1'b1};
            pending_events.push_back(ev);
        end else if (op == dltq_pkg::OP_STOP) begin
            ok = list_remove(id);
            ev = '{kind: dltq_pkg::EV_STOP, id: id, ok: ok, last: 1'b1};
            pending_events.push_back(ev);
        end else if (op == dltq_pkg::OP_TICK) begin
            more = !q_empty;
            while (more && k < NT) begin
                t = q_head;
                more = 0;
                if (q_delta[t] != 0) q_delta[t] = q_delta[t] - 1;
                if (q_delta[t] == 0) begin
                    q_linked[t] = 0;
                    if (q_nvalid[t]) q_head = q_next[t];
                    else q_empty = 1;
                    more = !q_empty && q_delta[q_head] == 0;
                    if (q_reload[t]) list_insert(t, q_period[t]);
                    ev = '{kind: dltq_pkg::EV_EXPIRE, id: t, ok: 1'b1, last: 1'b0};
                    pending_events.push_back(ev);
                    k++;
                end
            end
            if (k > 0) pending_events[pending_events.size() - 1].last = 1'b1;
        end
    endfunction

    // Send one operation with a random gap ahead of it; tvalid stays up after
    // the transfer until the next call or the drain lowers it
    task automatic send_op(logic [1:0] op, logic [3:0] id, logic [31:0] p, logic rl,
                           bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, rl, p, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_events(op, id, p, rl);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Receiver: draw a wait after each transfer, plus an optional long hold-off
    always @(posedge aclk) begin
        int w;
        w = $urandom_range(0, 15);
        cycle_count <= cycle_count + 1;
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready && w > 0) begin
            rx_wait  <= w - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest pending event
    always @(posedge aclk) begin
        timer_event_t exp_ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result: kind %0d id %0d", m_tuser, m_tdata[3:0]);
                error_count++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_tuser !== exp_ev.kind) begin
                    $error("event_kind: expected %0d, got %0d", exp_ev.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[3:0] !== exp_ev.id) begin
                    $error("timer_id_res: expected %0d, got %0d", exp_ev.id, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[4] !== exp_ev.ok) begin
                    $error("ok: expected %0d, got %0d", exp_ev.ok, m_tdata[4]);
                    error_count++;
                end
                if (m_tlast !== exp_ev.last) begin
                    $error("last: expected %0d, got %0d", exp_ev.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Edge cases: zero period, relink, stop of idle slot, ties, wrap, unused op
    task automatic test_directed();
        send_op(dltq_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        send_op(dltq_pkg::OP_STOP, 4'd3, 32'd0, 1'b0);
        send_op(dltq_pkg::OP_START, 4'd0, 32'd0, 1'b1);
        send_op(dltq_pkg::OP_START, 4'd0, 32'd3, 1'b0);
        send_op(dltq_pkg::OP_START, 4'd1, 32'd3, 1'b1);
        send_op(dltq_pkg::OP_START, 4'd2, 32'd5, 1'b0);
        send_op(dltq_pkg::OP_START, 4'd3, 32'd5, 1'b0);
        send_op(dltq_pkg::OP_START, 4'd1, 32'd9, 1'b0);
        send_op(dltq_pkg::OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_op(OP_UNUSED, 4'd5, 32'hAAAA_5555, 1'b1);
        send_op(dltq_pkg::OP_STOP, 4'd2, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 6; i++)
            send_op(dltq_pkg::OP_TICK, 4'hF, 32'h5555_AAAA, 1'b1);
        send_op(dltq_pkg::OP_STOP, 4'd15, 32'd0, 1'b0);
        send_op(dltq_pkg::OP_STOP, 4'd1, 32'd0, 1'b0);
        drain();
    endtask

    // All sixteen slots expire on one tick
    task automatic test_full_expiry();
        for (int i = 0; i < NT; i++)
            send_op(dltq_pkg::OP_START, 4'(i), 32'd1, 1'(i[0]));
        send_op(dltq_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        send_op(dltq_pkg::OP_TICK, 4'd0, 32'd0, 1'b0);
        for (int i = 0; i < NT; i++) send_op(dltq_pkg::OP_STOP, 4'(i), 32'd0, 1'b0);
        drain();
    endtask

    // Long receiver hold-off while starts and stops keep coming
    task automatic test_backpressure();
        rx_hold <= 400;
        for (int i = 0; i < 40; i++)
            send_op(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    32'($urandom_range(1, 20)), 1'($urandom_range(0, 1)), 1);
        drain();
    endtask

    // Random mix weighted toward small periods and frequent ticks
    task automatic test_random(int count);
        logic [1:0]  op;
        logic [31:0] p;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? dltq_pkg::OP_TICK : (r < 75) ? dltq_pkg::OP_START :
                 (r < 97) ? dltq_pkg::OP_STOP : OP_UNUSED;
            r = $urandom_range(0, 99);
            p = (r < 80) ? 32'($urandom_range(1, 12)) : (r < 85) ? 32'd0 :
                (r < 92) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
            send_op(op, 4'($urandom_range(0, 15)), p, 1'($urandom_range(0, 3) == 0));
        end
        drain();
    endtask

    initial begin
        list_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_expiry();
        test_backpressure();
        test_random(360);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/dltq_pkg.sv
design/dltq_alu.sv
design/delta_list_timer_queue.sv
dv/testbench.sv
